FILE: src/rpn_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpn_pkg
// Shared widths, token and status codes, and the request/response types of
// the iterative arithmetic unit.
// ============================================================================
package rpn_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int STEP_W      = $clog2(DATA_W);
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 3;

    // token kinds
    localparam logic [MODE_W-1:0] MODE_NUM = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVF  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LEFT = 3'd5;

    typedef struct packed {
        logic              start;
        logic [MODE_W-1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

FILE: src/rpn_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/rpn_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// rpn_alu
// Iterative arithmetic unit: add/subtract straight away, multiply by
// shift-and-add and divide by restoring division, one bit per cycle.
// ============================================================================
module rpn_alu (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rpn_pkg::alu_req_t         req,
    input  logic [rpn_pkg::DATA_W-1:0] a,
    input  logic [rpn_pkg::DATA_W-1:0] b,
    output rpn_pkg::alu_rsp_t         rsp
);
    import rpn_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [MODE_W-1:0] op_reg, op_next;
    logic [DATA_W-1:0] acc_reg, acc_next;   // product / remainder
    logic [DATA_W-1:0] x_reg, x_next;       // multiplicand / quotient
    logic [DATA_W-1:0] y_reg, y_next;       // multiplier / divisor
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;

    assign a_mag  = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign b_mag  = b[DATA_W-1] ? (~b + 1'b1) : b;
    assign rem_sh = {acc_reg, x_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, y_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            op_next  = req.op;
            cnt_next = '0;
            unique case (req.op)
                MODE_ADD:
                begin
                    acc_next  = a + b;
                    done_next = 1'b1;
                end
                MODE_SUB:
                begin
                    acc_next  = a - b;
                    done_next = 1'b1;
                end
                MODE_MUL:
                begin
                    acc_next  = '0;
                    x_next    = a;
                    y_next    = b;
                    busy_next = 1'b1;
                end
                MODE_DIV:
                begin
                    acc_next  = '0;
                    x_next    = a_mag;
                    y_next    = b_mag;
                    neg_next  = a[DATA_W-1] ^ b[DATA_W-1];
                    busy_next = 1'b1;
                end
                default:
                begin
                    acc_next  = '0;
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == MODE_MUL)
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[DATA_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[DATA_W-1:1]};
            end
            else
            begin
                // restoring step: shift in next dividend bit, try subtract
                if (!diff[DATA_W])
                begin
                    acc_next = diff[DATA_W-1:0];
                    x_next   = {x_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[DATA_W-1:0];
                    x_next   = {x_reg[DATA_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (op_reg == MODE_DIV)
        begin
            rsp.result = neg_reg ? (~x_reg + 1'b1) : x_reg;
        end
        else
        begin
            rsp.result = acc_reg;
        end
    end

endmodule

FILE: src/rpn_stack_evaluator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// rpn_stack_evaluator_core
// Postfix (reverse Polish) 32-bit integer expression evaluator.
// ============================================================================
// Tokens come in one per transfer on the slave stream, already classified by
// tuser (0 number, 1 add, 2 subtract, 3 multiply, 4 divide, anything else a
// bad token); tlast marks the last token of an expression. Numbers are pushed
// on an operand stack held in a RAM; an operator pops its right then left
// operand and pushes the result, wrapping at 32 bits, with division
// truncating toward zero. The first error is latched and later tokens are
// dropped. The last token produces one transfer on the master stream: the
// value in tdata (0 unless ok) and a status code in tuser (0 ok, 1 too few
// operands, 2 divide by zero, 3 bad token, 4 overflow, 5 leftover entries);
// the stack and error are then cleared. An operator reads its two operands
// from the RAM and then waits on the shared arithmetic unit, which works
// through multiply and divide one bit per cycle, and a last token then
// passes the end check and output load. The block takes one token at a
// time. Results wait in an output register, so the next token is accepted
// while a result is still pending on the master side.
// ============================================================================
module rpn_stack_evaluator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream: tokens
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rpn_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] number_value
    input  logic                          s_axis_tlast,   // is_last
    input  logic [rpn_pkg::MODE_W-1:0]    s_axis_tuser,   // [2:0] mode
    // master stream: results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rpn_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] result_value
    output logic [rpn_pkg::STATUS_W-1:0]  m_axis_tuser    // [2:0] status
);
    import rpn_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,   // waiting for a token
        S_RDB  = 6'b000010,   // right operand on RAM output
        S_RDA  = 6'b000100,   // left operand on RAM output, start unit
        S_CALC = 6'b001000,   // wait for arithmetic unit
        S_END  = 6'b010000,   // read bottom entry for end check
        S_EMIT = 6'b100000    // load output register
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                last_reg, last_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // RAM ports
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    logic                in_xfer;
    logic                out_free;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;
    logic [STATUS_W-1:0] end_status;
    state_t              after_tok;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_m2   = count_reg - 2'd2;

    // where a token goes once it has been applied
    assign after_tok = last_reg ? S_END : S_IDLE;

    assign end_status = (err_reg != ST_OK) ? err_reg :
                        (count_reg == CNT_W'(1)) ? ST_OK : ST_LEFT;

    assign s_axis_tready = (state_reg == S_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        mode_next       = mode_reg;
        last_next       = last_reg;
        b_next          = b_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = count_reg[ADDR_W-1:0];
        ram_wr_data     = s_axis_tdata;
        ram_rd_addr     = '0;
        alu_req.start   = 1'b0;
        alu_req.op      = mode_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = cnt_m1[ADDR_W-1:0];
                if (in_xfer)
                begin
                    mode_next  = s_axis_tuser;
                    last_next  = s_axis_tlast;
                    state_next = s_axis_tlast ? S_END : S_IDLE;
                    priority if (err_reg != ST_OK)
                    begin
                        // token dropped after an error
                    end
                    else if (s_axis_tuser == MODE_NUM)
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            err_next = ST_OVF;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (s_axis_tuser > MODE_DIV)
                    begin
                        err_next = ST_BAD;
                    end
                    else if (count_reg < CNT_W'(2))
                    begin
                        err_next = ST_FEW;
                    end
                    else
                    begin
                        state_next = S_RDB;
                    end
                end
            end
            S_RDB:
            begin
                b_next      = ram_rd_data;
                ram_rd_addr = cnt_m2[ADDR_W-1:0];
                state_next  = S_RDA;
            end
            S_RDA:
            begin
                if (mode_reg == MODE_DIV && b_reg == '0)
                begin
                    err_next   = ST_DIVZ;
                    state_next = after_tok;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = S_CALC;
                end
            end
            S_CALC:
            begin
                if (alu_rsp.done)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cnt_m2[ADDR_W-1:0];
                    ram_wr_data = alu_rsp.result;
                    count_next  = cnt_m1;
                    state_next  = after_tok;
                end
            end
            S_END:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = end_status;
                    out_value_next  = (end_status == ST_OK) ? ram_rd_data : '0;
                    count_next      = '0;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        last_reg       <= last_next;
        b_reg          <= b_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (ram_rd_data),
        .b     (b_reg),
        .rsp   (alu_rsp)
    );

endmodule

FILE: bench/rpn_stack_evaluator_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rpn_stack_evaluator_core_tb
// Self-checking bench for the postfix expression evaluator.
// ============================================================================
// Tokens go in on the slave stream, results come back on the master stream.
// A shadow evaluator in the bench tracks stack, depth and latched fault and
// works out the value and status each last token must yield. A short table
// of tokens runs first (extremes, each operator, each fault bar overflow).
// Random expressions follow: mostly well formed, some broken, and one that
// fills the stack to the brim or past it in each phase. The phases vary how
// often the token source idles and the result sink stalls.
// ============================================================================
module rpn_stack_evaluator_core_tb;

    import rpn_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    // no-transfer cycles before the run is declared hung; it allows for a
    // multiply or divide plus the end check, and for sink stalls
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int NUM_PHASES      = 4;
    localparam int DIRECTED_N      = 25;

    // token kinds outside the defined set
    localparam logic [MODE_W-1:0] MODE_BAD   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } eval_result_t;

    // one table row; pinned rows carry a hand-written answer
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [DATA_W-1:0]   number;
        logic                last;
        logic                pinned;
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } token_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata;   // [31:0] number_value
    logic                 s_axis_tlast;   // is_last
    logic [MODE_W-1:0]    s_axis_tuser;   // [2:0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;   // [31:0] result_value
    logic [STATUS_W-1:0]  m_axis_tuser;   // [2:0] status

    // shadow copy of the evaluator state
    logic [DATA_W-1:0]    shadow_stack [STACK_DEPTH];
    int                   shadow_count;
    logic [STATUS_W-1:0]  shadow_fault;

    eval_result_t         awaited_answers [$];
    int                   tokens_applied;
    int                   mismatches = 0;
    int                   idle_cycles = 0;
    int                   send_idle_pct;
    int                   recv_stall_pct;

    token_row_t directed_rows [DIRECTED_N] = '{
        // extremes pushed alone
        '{MODE_NUM,   32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, ST_OK},
        '{MODE_NUM,   32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, ST_OK},
        // operator on an empty stack
        '{MODE_ADD,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, ST_FEW},
        // divide by zero
        '{MODE_NUM,   32'h0000_0009, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_DIV,   32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000, ST_DIVZ},
        // most negative / -1 wraps back to most negative
        '{MODE_NUM,   32'h8000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'hffff_ffff, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_DIV,   32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, ST_OK},
        // add wrapping past the top
        '{MODE_NUM,   32'h7fff_ffff, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0001, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_ADD,   32'h0000_0000, 1'b1, 1'b0, 32'h0,         ST_OK},
        // (-7 / 2) * 6 - 4, truncating division on a negative dividend
        '{MODE_NUM,   32'hffff_fff9, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0002, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_DIV,   32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0006, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_MUL,   32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0004, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_SUB,   32'h0000_0000, 1'b1, 1'b0, 32'h0,         ST_OK},
        // unrecognized and undefined token kinds
        '{MODE_BAD,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, ST_BAD},
        '{MODE_RSVD6, 32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000, ST_BAD},
        // tokens after an error are dropped, the last one still reports
        '{MODE_RSVD7, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0003, 1'b1, 1'b1, 32'h0000_0000, ST_BAD},
        // two entries left at the end
        '{MODE_NUM,   32'h0000_0001, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{MODE_NUM,   32'h0000_0002, 1'b1, 1'b1, 32'h0000_0000, ST_LEFT}
    };

    rpn_stack_evaluator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow evaluator: applies one accepted token. applied is low when a
    // latched fault makes the block drop the token; produced is high on a
    // last token, with the answer in res.
    // ------------------------------------------------------------------------
    task automatic evaluate_token(input logic [MODE_W-1:0] mode,
                                  input logic [DATA_W-1:0] num,
                                  input logic last,
                                  output bit applied,
                                  output bit produced,
                                  output eval_result_t res);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] acc;
        int                lhs_s;
        int                rhs_s;
        applied = (shadow_fault == ST_OK);
        acc     = '0;
        if (applied)
        begin
            if (mode == MODE_NUM)
            begin
                if (shadow_count >= STACK_DEPTH)
                    shadow_fault = ST_OVF;
                else
                begin
                    shadow_stack[shadow_count] = num;
                    shadow_count++;
                end
            end
            else if (mode > MODE_DIV)
                shadow_fault = ST_BAD;
            else if (shadow_count < 2)
                shadow_fault = ST_FEW;
            else
            begin
                // right operand on top, left one below it
                rhs = shadow_stack[shadow_count - 1];
                lhs = shadow_stack[shadow_count - 2];
                case (mode)
                    MODE_ADD: acc = lhs + rhs;
                    MODE_SUB: acc = lhs - rhs;
                    MODE_MUL: acc = lhs * rhs;
                    default:
                    begin
                        if (rhs == '0)
                            shadow_fault = ST_DIVZ;
                        else if (lhs == 32'h8000_0000 && rhs == 32'hffff_ffff)
                            acc = lhs;
                        else
                        begin
                            lhs_s = lhs;
                            rhs_s = rhs;
                            acc   = lhs_s / rhs_s;
                        end
                    end
                endcase
                // a fault leaves the stack as it was
                if (shadow_fault == ST_OK)
                begin
                    shadow_count--;
                    shadow_stack[shadow_count - 1] = acc;
                end
            end
        end
        produced = last;
        res      = '0;
        if (last)
        begin
            res.status = shadow_fault;
            if (shadow_fault == ST_OK)
            begin
                if (shadow_count == 1)
                    res.value = shadow_stack[0];
                else
                    res.status = ST_LEFT;
            end
            shadow_count = 0;
            shadow_fault = ST_OK;
        end
    endtask

    // ------------------------------------------------------------------------
    // Token source. Idle cycles are decided at each falling edge; the token
    // is held until a rising edge sees tready, then the shadow evaluator runs.
    // ------------------------------------------------------------------------
    task automatic send_token(input logic [MODE_W-1:0] mode,
                              input logic [DATA_W-1:0] num,
                              input logic last,
                              input bit pinned,
                              input eval_result_t pinned_res);
        bit           applied;
        bit           produced;
        eval_result_t res;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) >= send_idle_pct)
                break;
            s_axis_tvalid <= 1'b0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= num;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        evaluate_token(mode, num, last, applied, produced, res);
        if (applied)
            tokens_applied++;
        if (produced)
            awaited_answers.push_back(pinned ? pinned_res : res);
    endtask

    // operands lean on small values so divides by zero and exact
    // quotients turn up, with the extremes mixed in
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: return $urandom_range(0, 16) - 32'd8;
            5:             return 32'h0000_0000;
            6:             return 32'h8000_0000;
            7:             return 32'h7fff_ffff;
            8:             return 32'hffff_ffff;
            default:       return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return MODE_ADD;
            1:       return MODE_SUB;
            2:       return MODE_MUL;
            default: return MODE_DIV;
        endcase
    endfunction

    // fill the stack with pushes, then fold it back with operators; one
    // push past the depth latches an overflow and the rest is dropped
    task automatic play_deep_expression(input int pushes);
        int folds;
        folds = ((pushes > STACK_DEPTH) ? STACK_DEPTH : pushes) - 1;
        for (int i = 0; i < pushes; i++)
            send_token(MODE_NUM, pick_operand(), 1'b0, 1'b0, '0);
        for (int i = 0; i < folds; i++)
            send_token(pick_operator(), $urandom, (i == folds - 1), 1'b0, '0);
    endtask

    task automatic play_random_expression();
        int  kind;
        int  pushes;
        int  ops;
        int  depth;
        int  len;
        kind = $urandom_range(0, 99);
        if (kind < 72)
        begin
            // well formed: depth + pushes left - ops left stays at one
            ops    = $urandom_range(0, 5);
            pushes = ops + 1;
            depth  = 0;
            while (pushes + ops > 0)
            begin
                if (depth < 2 || ops == 0 || (pushes > 0 && $urandom_range(0, 1) == 1))
                begin
                    send_token(MODE_NUM, pick_operand(), (pushes + ops == 1), 1'b0, '0);
                    pushes--;
                    depth++;
                end
                else
                begin
                    send_token(pick_operator(), $urandom, (pushes + ops == 1), 1'b0, '0);
                    ops--;
                    depth--;
                end
            end
        end
        else if (kind < 90)
        begin
            // noise: any token kind in any order
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                send_token(MODE_W'($urandom_range(0, 7)), pick_operand(),
                           (i == len - 1), 1'b0, '0);
        end
        else
        begin
            // pushes with no operator between them
            len = $urandom_range(2, 4);
            for (int i = 0; i < len; i++)
                send_token(MODE_NUM, pick_operand(), (i == len - 1), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: tready toggles at falling edges, transfers are checked
    // at rising edges against the oldest awaited answer.
    // ------------------------------------------------------------------------
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        eval_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_answers.size() == 0)
            begin
                $display("%0t: unexpected result: value %h status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = awaited_answers.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.status)
                begin
                    $display("%0t: expected value %h status %0d, got value %h status %0d",
                             $time, want.value, want.status, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: no transfer on either side for too long means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int send_pct_by_phase [NUM_PHASES];
        int recv_pct_by_phase [NUM_PHASES];
        int target;
        send_pct_by_phase = '{0, 51, 0, 16};
        recv_pct_by_phase = '{0, 0, 51, 16};
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = MODE_NUM;
        s_axis_tlast   = 1'b0;
        shadow_count   = 0;
        shadow_fault   = ST_OK;
        tokens_applied = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < STACK_DEPTH; i++)
            shadow_stack[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, streamed back to back
        for (int i = 0; i < DIRECTED_N; i++)
            send_token(directed_rows[i].mode, directed_rows[i].number,
                       directed_rows[i].last, directed_rows[i].pinned,
                       '{directed_rows[i].value, directed_rows[i].status});

        // random phases; odd phases push one past the depth
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = send_pct_by_phase[p];
            recv_stall_pct = recv_pct_by_phase[p];
            play_deep_expression((p % 2 == 1) ? STACK_DEPTH + 1 : STACK_DEPTH);
            target = tokens_applied + ITEMS_PER_PHASE;
            while (tokens_applied < target)
                play_random_expression();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // the watchdog bounds this wait
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
src/rpn_pkg.sv
src/rpn_ram.sv
src/rpn_alu.sv
src/rpn_stack_evaluator_core.sv
bench/rpn_stack_evaluator_core_tb.sv
